// ===== design/rhd_pkg.sv =====
`timescale 1ns / 1ps

package rhd_pkg;

  localparam int HDR_BYTES = 16;
  localparam int POS_W     = $clog2(HDR_BYTES);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(HDR_BYTES - 1);

  // signature bytes
  localparam logic [7:0] SIG_0 = 8'h4E;
  localparam logic [7:0] SIG_1 = 8'h45;
  localparam logic [7:0] SIG_2 = 8'h53;
  localparam logic [7:0] SIG_3 = 8'h1A;

  // byte 7 version field
  localparam logic [7:0] VER_MASK = 8'h0C;
  localparam logic [7:0] VER_EXT  = 8'h08;

  localparam logic [3:0] EXP_FORM = 4'hF;

  localparam logic FMT_ARCHAIC  = 1'b0;
  localparam logic FMT_STANDARD = 1'b1;

  localparam logic [13:0] CHR_RAM_DEFAULT = 14'd8192;
  localparam logic [20:0] PRG_RAM_DEFAULT = 21'd8192;

  typedef logic [HDR_BYTES-1:0][7:0] header_t;

  typedef struct packed {
    logic valid;  // an item sits in the capture register
    logic emit;   // that item is byte 15 and completes a header
    logic fire;   // the item leaves the capture register this cycle
  } coll_ctl_t;

  typedef struct packed {
    logic        signature_ok;
    logic        format_kind;
    logic [21:0] prg_rom_bytes;
    logic [20:0] chr_rom_bytes;
    logic [13:0] chr_ram_bytes;
    logic [20:0] prg_ram_bytes;
    logic [7:0]  mapper_number;
    logic [3:0]  nametable_flags;
    logic        vs_system;
    logic        pal_tv;
    logic        size_consistent;
  } record_t;

endpackage

// ===== design/rhd_collect.sv =====
`timescale 1ns / 1ps

module rhd_collect import rhd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_header_byte,
  input  logic             in_first_byte,
  input  logic             out_free,
  output coll_ctl_t        ctl,
  output header_t          hdr
);

  logic             valid_r, valid_nxt;
  logic [POS_W-1:0] bpos_r, bpos_nxt;
  logic [POS_W-1:0] pos_r;
  logic [7:0]       byte_r;
  logic [7:0]       store_r [HDR_BYTES-1];
  logic [POS_W-1:0] pos_in;
  logic             accept;

  assign ctl.valid = valid_r;
  assign ctl.emit  = valid_r && (pos_r == LAST_POS);
  assign ctl.fire  = valid_r && (!ctl.emit || out_free);
  assign in_ready  = !valid_r || ctl.fire;
  assign accept    = in_valid && in_ready;

  assign pos_in = in_first_byte ? '0 : bpos_r;

  always_comb begin
    valid_nxt = valid_r;
    bpos_nxt  = bpos_r;
    if (accept) begin
      valid_nxt = 1'b1;
      bpos_nxt  = pos_in + 1'b1;
    end else if (ctl.fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      bpos_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      bpos_r  <= bpos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r  <= pos_in;
      byte_r <= in_header_byte;
    end
  end

  // byte 15 is never stored, it is read straight from the capture register
  always_ff @(posedge clk) begin
    if (ctl.fire && (pos_r != LAST_POS)) begin
      store_r[pos_r] <= byte_r;
    end
  end

  always_comb begin
    for (int i = 0; i < HDR_BYTES - 1; i++) begin
      hdr[i] = store_r[i];
    end
    hdr[HDR_BYTES-1] = byte_r;
  end

endmodule

// ===== design/rhd_decode.sv =====
`timescale 1ns / 1ps

module rhd_decode import rhd_pkg::*; (
  input  header_t     hdr,
  input  logic [31:0] rom_file_bytes,
  output record_t     rec
);

  typedef struct packed {
    logic        big;  // section alone exceeds any 32-bit image size
    logic [35:0] val;
  } sect_t;

  function automatic sect_t ext_section(input logic [7:0] lsb, input logic [3:0] msb,
                                        input logic is_prg);
    sect_t      s;
    logic [5:0] e;
    logic [2:0] m;
    e = lsb[7:2];
    m = {lsb[1:0], 1'b1};
    s.big = 1'b0;
    s.val = '0;
    if (msb == EXP_FORM) begin
      if (e > 6'd32) begin
        s.big = 1'b1;
      end else begin
        s.val = {33'd0, m} << e;
      end
    end else if (is_prg) begin
      s.val = {10'd0, msb, lsb, 14'd0};
    end else begin
      s.val = {11'd0, msb, lsb, 13'd0};
    end
    return s;
  endfunction

  sect_t       prg_ext, chr_ext;
  logic [36:0] ext_sum;
  logic        ext_match;
  logic        sig_ok;
  logic        archaic;
  logic [21:0] prg;
  logic [20:0] chr;
  logic [22:0] rom_sum;

  assign sig_ok = (hdr[0] == SIG_0) && (hdr[1] == SIG_1) &&
                  (hdr[2] == SIG_2) && (hdr[3] == SIG_3);

  assign prg_ext = ext_section(hdr[4], hdr[9][3:0], 1'b1);
  assign chr_ext = ext_section(hdr[5], hdr[9][7:4], 1'b0);
  assign ext_sum = {1'b0, prg_ext.val} + {1'b0, chr_ext.val} + 37'd16;

  assign ext_match = ((hdr[7] & VER_MASK) == VER_EXT) && !prg_ext.big && !chr_ext.big &&
                     (ext_sum <= {5'd0, rom_file_bytes});

  assign archaic = !ext_match &&
                   ((hdr[12] | hdr[13] | hdr[14] | hdr[15]) != 8'd0);

  assign prg     = {hdr[4], 14'd0};
  assign chr     = {hdr[5], 13'd0};
  assign rom_sum = {1'b0, prg} + {2'b0, chr} + 23'd16;

  always_comb begin
    rec = '0;
    if (sig_ok) begin
      rec.signature_ok    = 1'b1;
      rec.format_kind     = archaic ? FMT_ARCHAIC : FMT_STANDARD;
      rec.prg_rom_bytes   = prg;
      rec.chr_rom_bytes   = chr;
      rec.chr_ram_bytes   = (hdr[5] == 8'd0) ? CHR_RAM_DEFAULT : '0;
      rec.nametable_flags = hdr[6][3:0];
      rec.size_consistent = ({9'd0, rom_sum} == rom_file_bytes);
      if (archaic) begin
        rec.mapper_number = {4'd0, hdr[6][7:4]};
      end else begin
        rec.prg_ram_bytes = (hdr[8] == 8'd0) ? PRG_RAM_DEFAULT : {hdr[8], 13'd0};
        rec.mapper_number = {hdr[7][7:4], hdr[6][7:4]};
        rec.vs_system     = hdr[7][0];
        rec.pal_tv        = hdr[9][0];
      end
    end
  end

endmodule

// ===== design/rom_header_decoder_core.sv =====
`timescale 1ns / 1ps

// cartridge header decoder: header bytes arrive one per transaction on the in_
// channel, byte 0 flagged by in_first_byte, and one decoded record leaves on
// the out_ channel after byte 15 (other bytes give no output). a new byte can
// be taken every cycle; byte 15 reaches its record through the capture
// register and then the record register, with the whole decode
// in between. the record register frees the input side, so bytes keep flowing
// while a record waits, and only a second record meeting a full, stalled
// output register holds the input. cfg_rom_file_bytes (image size, reset 0) is
// written through the cfg_ channel, which is always ready, and should only
// change while no header is in flight. a record with a bad signature has
// every field zero.

module rom_header_decoder_core import rhd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,

  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_rom_file_bytes,

  // header byte stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_header_byte,
  input  logic        in_first_byte,

  // decoded record
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_signature_ok,
  output logic        out_format_kind,
  output logic [21:0] out_prg_rom_bytes,
  output logic [20:0] out_chr_rom_bytes,
  output logic [13:0] out_chr_ram_bytes,
  output logic [20:0] out_prg_ram_bytes,
  output logic [7:0]  out_mapper_number,
  output logic [3:0]  out_nametable_flags,
  output logic        out_vs_system,
  output logic        out_pal_tv,
  output logic        out_size_consistent
);

  logic [31:0] rom_bytes_r;
  logic        out_valid_r, out_valid_nxt;
  record_t     rec_r;
  record_t     rec;
  header_t     hdr;
  coll_ctl_t   ctl;
  logic        out_free;
  logic        load;

  // image size register, written whenever a cfg transaction completes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bytes_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      rom_bytes_r <= cfg_rom_file_bytes;
    end
  end

  // record register can take a new record when empty or being drained
  assign out_free = !out_valid_r || out_ready;

  rhd_collect u_collect (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_header_byte (in_header_byte),
    .in_first_byte  (in_first_byte),
    .out_free       (out_free),
    .ctl            (ctl),
    .hdr            (hdr)
  );

  rhd_decode u_decode (
    .hdr            (hdr),
    .rom_file_bytes (rom_bytes_r),
    .rec            (rec)
  );

  // a completed header moves into the record register
  assign load = ctl.fire && ctl.emit;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_r <= rec;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_signature_ok    = rec_r.signature_ok;
  assign out_format_kind     = rec_r.format_kind;
  assign out_prg_rom_bytes   = rec_r.prg_rom_bytes;
  assign out_chr_rom_bytes   = rec_r.chr_rom_bytes;
  assign out_chr_ram_bytes   = rec_r.chr_ram_bytes;
  assign out_prg_ram_bytes   = rec_r.prg_ram_bytes;
  assign out_mapper_number   = rec_r.mapper_number;
  assign out_nametable_flags = rec_r.nametable_flags;
  assign out_vs_system       = rec_r.vs_system;
  assign out_pal_tv          = rec_r.pal_tv;
  assign out_size_consistent = rec_r.size_consistent;

endmodule

// ===== tb/sv/rom_header_decoder_checker.sv =====
`timescale 1ns / 1ps

module rom_header_decoder_checker import rhd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_rom_file_bytes,

  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_header_byte,
  input  logic        in_first_byte,

  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_signature_ok,
  input  logic        out_format_kind,
  input  logic [21:0] out_prg_rom_bytes,
  input  logic [20:0] out_chr_rom_bytes,
  input  logic [13:0] out_chr_ram_bytes,
  input  logic [20:0] out_prg_ram_bytes,
  input  logic [7:0]  out_mapper_number,
  input  logic [3:0]  out_nametable_flags,
  input  logic        out_vs_system,
  input  logic        out_pal_tv,
  input  logic        out_size_consistent,

  output int          error_count,
  output int          outstanding,
  output int          records_checked,
  output int          bad_sig_count,
  output int          archaic_count,
  output int          consistent_count
);

  localparam logic [63:0] SAT40 = 64'hFF_FFFF_FFFF;
  localparam int SHOWN_MISMATCHES = 10;

  header_t          header_bytes;
  logic [POS_W-1:0] next_slot;
  logic [31:0]      image_bytes;
  record_t          expected_records[$];

  // size of one section under the extended header rules
  function automatic logic [63:0] section_bytes(logic [7:0] lsb, logic [3:0] msb,
                                                logic [63:0] unit);
    logic [63:0] span;
    if (msb != EXP_FORM) begin
      return {52'b0, msb, lsb} * unit;
    end
    if (lsb[7:2] >= 6'd40) begin
      return SAT40;
    end
    span = (64'd1 << lsb[7:2]) * {61'b0, lsb[1:0], 1'b1};
    return (span > SAT40) ? SAT40 : span;
  endfunction

  function automatic record_t decode_header(header_t h, logic [31:0] image);
    record_t     rec;
    logic [63:0] ext_total;
    logic [63:0] prg;
    logic [63:0] chr;
    logic        v2_fits;
    logic        archaic;
    rec = '0;
    if (h[0] != SIG_0 || h[1] != SIG_1 || h[2] != SIG_2 || h[3] != SIG_3) begin
      return rec;
    end
    ext_total = section_bytes(h[4], h[9][3:0], 64'h4000)
              + section_bytes(h[5], h[9][7:4], 64'h2000) + 64'd16;
    if (ext_total > SAT40) begin
      ext_total = SAT40;
    end
    v2_fits = ((h[7] & VER_MASK) == VER_EXT) && (ext_total <= {32'b0, image});
    archaic = !v2_fits && ((h[12] | h[13] | h[14] | h[15]) != 8'h00);
    prg = {42'b0, h[4], 14'b0};
    chr = {43'b0, h[5], 13'b0};

    rec.signature_ok    = 1'b1;
    rec.format_kind     = archaic ? FMT_ARCHAIC : FMT_STANDARD;
    rec.prg_rom_bytes   = prg[21:0];
    rec.chr_rom_bytes   = chr[20:0];
    rec.chr_ram_bytes   = (chr == 64'd0) ? CHR_RAM_DEFAULT : 14'd0;
    rec.nametable_flags = h[6][3:0];
    rec.size_consistent = (prg + chr + 64'd16) == {32'b0, image};
    if (archaic) begin
      rec.mapper_number = {4'h0, h[6][7:4]};
    end else begin
      rec.prg_ram_bytes = (h[8] == 8'h00) ? PRG_RAM_DEFAULT : {h[8], 13'b0};
      rec.mapper_number = {h[7][7:4], h[6][7:4]};
      rec.vs_system     = h[7][0];
      rec.pal_tv        = h[9][0];
    end
    return rec;
  endfunction

  task automatic flag_field(string field, logic [63:0] want, logic [63:0] got);
    if (want != got) begin
      error_count++;
      if (error_count <= SHOWN_MISMATCHES) begin
        $display("record %0d %s: expected 0x%0h, got 0x%0h",
                 records_checked, field, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    record_t          want;
    record_t          got;
    logic [POS_W-1:0] slot;
    if (!rst_n) begin
      expected_records.delete();
      header_bytes = '0;
      next_slot    = '0;
      image_bytes  = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        image_bytes = cfg_rom_file_bytes;
      end
      // results first, so a record can never match an expectation queued this edge
      if (out_valid && out_ready) begin
        got = {out_signature_ok, out_format_kind, out_prg_rom_bytes, out_chr_rom_bytes,
               out_chr_ram_bytes, out_prg_ram_bytes, out_mapper_number,
               out_nametable_flags, out_vs_system, out_pal_tv, out_size_consistent};
        if (expected_records.size() == 0) begin
          error_count++;
          if (error_count <= SHOWN_MISMATCHES) begin
            $display("record with no completed header behind it: 0x%0h", got);
          end
        end else begin
          want = expected_records.pop_front();
          flag_field("signature_ok", 64'(want.signature_ok), 64'(got.signature_ok));
          flag_field("format_kind", 64'(want.format_kind), 64'(got.format_kind));
          flag_field("prg_rom_bytes", 64'(want.prg_rom_bytes), 64'(got.prg_rom_bytes));
          flag_field("chr_rom_bytes", 64'(want.chr_rom_bytes), 64'(got.chr_rom_bytes));
          flag_field("chr_ram_bytes", 64'(want.chr_ram_bytes), 64'(got.chr_ram_bytes));
          flag_field("prg_ram_bytes", 64'(want.prg_ram_bytes), 64'(got.prg_ram_bytes));
          flag_field("mapper_number", 64'(want.mapper_number), 64'(got.mapper_number));
          flag_field("nametable_flags", 64'(want.nametable_flags),
                     64'(got.nametable_flags));
          flag_field("vs_system", 64'(want.vs_system), 64'(got.vs_system));
          flag_field("pal_tv", 64'(want.pal_tv), 64'(got.pal_tv));
          flag_field("size_consistent", 64'(want.size_consistent),
                     64'(got.size_consistent));
          records_checked++;
          if (!want.signature_ok) begin
            bad_sig_count++;
          end else if (want.format_kind == FMT_ARCHAIC) begin
            archaic_count++;
          end
          if (want.size_consistent) begin
            consistent_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        slot = in_first_byte ? '0 : next_slot;
        header_bytes[slot] = in_header_byte;
        next_slot = slot + 1'b1;
        if (slot == LAST_POS) begin
          expected_records.push_back(decode_header(header_bytes, image_bytes));
        end
      end
    end
    outstanding <= expected_records.size();
  end

endmodule

// ===== tb/sv/rom_header_decoder_core_tb.sv =====
`timescale 1ns / 1ps

// stimulus and verdict for the header decoder; all prediction and comparison
// lives in the checker instantiated beside the block

module rom_header_decoder_core_tb;
  import rhd_pkg::*;

  localparam int PHASES            = 6;
  localparam int HEADERS_PER_PHASE = 13;
  localparam int SETTLE_CYCLES     = 8;     // settle time once every record is back
  localparam int LONG_HOLD         = 300;   // receiver hold-off to fill the block
  localparam int STALL_LIMIT       = 3000;  // cycles without any transaction

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_rom_file_bytes;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_header_byte;
  logic        in_first_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_signature_ok;
  logic        out_format_kind;
  logic [21:0] out_prg_rom_bytes;
  logic [20:0] out_chr_rom_bytes;
  logic [13:0] out_chr_ram_bytes;
  logic [20:0] out_prg_ram_bytes;
  logic [7:0]  out_mapper_number;
  logic [3:0]  out_nametable_flags;
  logic        out_vs_system;
  logic        out_pal_tv;
  logic        out_size_consistent;

  int error_count;
  int outstanding;
  int records_checked;
  int bad_sig_count;
  int archaic_count;
  int consistent_count;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_asks;        // bumped by the stimulus to ask for one long hold-off
  int stall_cycles;
  int bytes_sent;
  int sizes_used;

  // rom sizes the current image size is built from, so some headers add up
  logic [7:0] prg_pick;
  logic [7:0] chr_pick;
  logic       restart_due;  // last header was cut short, next one must restart

  rom_header_decoder_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_rom_file_bytes  (cfg_rom_file_bytes),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_header_byte      (in_header_byte),
    .in_first_byte       (in_first_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_signature_ok    (out_signature_ok),
    .out_format_kind     (out_format_kind),
    .out_prg_rom_bytes   (out_prg_rom_bytes),
    .out_chr_rom_bytes   (out_chr_rom_bytes),
    .out_chr_ram_bytes   (out_chr_ram_bytes),
    .out_prg_ram_bytes   (out_prg_ram_bytes),
    .out_mapper_number   (out_mapper_number),
    .out_nametable_flags (out_nametable_flags),
    .out_vs_system       (out_vs_system),
    .out_pal_tv          (out_pal_tv),
    .out_size_consistent (out_size_consistent)
  );

  rom_header_decoder_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_rom_file_bytes  (cfg_rom_file_bytes),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_header_byte      (in_header_byte),
    .in_first_byte       (in_first_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_signature_ok    (out_signature_ok),
    .out_format_kind     (out_format_kind),
    .out_prg_rom_bytes   (out_prg_rom_bytes),
    .out_chr_rom_bytes   (out_chr_rom_bytes),
    .out_chr_ram_bytes   (out_chr_ram_bytes),
    .out_prg_ram_bytes   (out_prg_ram_bytes),
    .out_mapper_number   (out_mapper_number),
    .out_nametable_flags (out_nametable_flags),
    .out_vs_system       (out_vs_system),
    .out_pal_tv          (out_pal_tv),
    .out_size_consistent (out_size_consistent),
    .error_count         (error_count),
    .outstanding         (outstanding),
    .records_checked     (records_checked),
    .bad_sig_count       (bad_sig_count),
    .archaic_count       (archaic_count),
    .consistent_count    (consistent_count)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // result side: random back-pressure, plus one long hold-off on request,
  // counted here so the sender keeps offering bytes meanwhile
  initial begin : result_sink
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles, %0d records still due",
               stall_cycles, outstanding);
      $display("rom_header_decoder_core test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one byte transaction; valid is only dropped when an idle gap follows,
  // so back-to-back bytes never lower and raise it in the same step
  task automatic push_byte(logic [7:0] value, logic first);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_header_byte <= value;
    in_first_byte  <= first;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // sends the first n_bytes of a header; byte 0 mostly carries the restart
  // flag, and always does after a cut-short header
  task automatic send_header(header_t h, int n_bytes);
    for (int i = 0; i < n_bytes; i++) begin
      push_byte(h[i], (i == 0) && (restart_due || $urandom_range(99) < 85));
    end
    restart_due = (n_bytes != HDR_BYTES);
  endtask

  // stop offering, wait until every record is back and the pipeline is empty
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_image_size(logic [31:0] bytes);
    cfg_valid          <= 1'b1;
    cfg_rom_file_bytes <= bytes;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sizes_used++;
  endtask

  // header with random content, weighted towards the corners:
  // bad signatures, matched rom sizes, empty chr rom, zero prg ram, the
  // version 2 flag, exponent-form sizes and nonzero trailing bytes
  function automatic header_t random_header();
    header_t h;
    h[0] = SIG_0;
    h[1] = SIG_1;
    h[2] = SIG_2;
    h[3] = SIG_3;
    if ($urandom_range(99) < 10) begin
      h[$urandom_range(3)] = 8'($urandom_range(255));
    end
    case ($urandom_range(9))
      0, 1, 2: h[4] = prg_pick;
      3:       h[4] = 8'h00;
      4:       h[4] = 8'hFF;
      default: h[4] = 8'($urandom_range(255));
    endcase
    case ($urandom_range(9))
      0, 1, 2: h[5] = chr_pick;
      3, 4:    h[5] = 8'h00;
      5:       h[5] = 8'hFF;
      default: h[5] = 8'($urandom_range(255));
    endcase
    h[6] = 8'($urandom_range(255));
    h[7] = 8'($urandom_range(255));
    if ($urandom_range(99) < 45) begin
      h[7][3:2] = 2'b10;
    end
    h[8] = ($urandom_range(99) < 25) ? 8'h00 : 8'($urandom_range(255));
    h[9] = 8'($urandom_range(255));
    case ($urandom_range(4))
      0: h[9] = 8'h00;
      1: h[9][3:0] = EXP_FORM;
      2: h[9][7:4] = EXP_FORM;
      3: h[9] = {EXP_FORM, EXP_FORM};
      default: ;
    endcase
    h[10] = 8'($urandom_range(255));
    h[11] = 8'($urandom_range(255));
    for (int i = 12; i < HDR_BYTES; i++) begin
      h[i] = ($urandom_range(99) < 60) ? 8'h00 : 8'($urandom_range(255));
    end
    if ($urandom_range(1) == 0) begin
      h[15:12] = '0;
    end
    return h;
  endfunction

  initial begin : stimulus
    header_t     h;
    logic [31:0] image;
    rst_n              = 1'b0;
    cfg_valid          = 1'b0;
    cfg_rom_file_bytes = '0;
    in_valid           = 1'b0;
    in_header_byte     = '0;
    in_first_byte      = 1'b0;
    hold_asks          = 0;
    bytes_sent         = 0;
    sizes_used         = 0;
    send_idle_pct      = 35;
    recv_idle_pct      = 63;
    restart_due        = 1'b0;
    prg_pick           = '0;
    chr_pick           = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      // idling: receiver-heavy gaps, then sender-heavy, then none at all
      if (ph < 2) begin
        send_idle_pct = 35;
        recv_idle_pct = 63;
      end else if (ph < 4) begin
        send_idle_pct = 63;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // image size for this phase, from zero up to the full 32-bit range;
      // most are built from chosen rom sizes so the sum check can succeed
      prg_pick = 8'($urandom_range(255));
      chr_pick = 8'($urandom_range(255));
      case (ph)
        0: image = 32'd0;
        1: image = 32'hFFFF_FFFF;
        3: begin
          prg_pick = 8'hFF;
          chr_pick = 8'hFF;
          image    = {10'b0, prg_pick, 14'b0} + {11'b0, chr_pick, 13'b0} + 32'd16;
        end
        4: begin
          prg_pick = 8'h00;
          chr_pick = 8'h00;
          image    = 32'd16;
        end
        default: image = {10'b0, prg_pick, 14'b0} + {11'b0, chr_pick, 13'b0} + 32'd16;
      endcase
      if (ph > 0) begin
        wait_quiet();
      end
      set_image_size(image);

      if (ph == 0) begin
        // a torn header restarted by the first-byte flag, then a header
        // with every byte after the signature at its maximum
        h    = '0;
        h[0] = SIG_0;
        h[1] = SIG_1;
        h[2] = 8'hFF;
        send_header(h, 3);
        h    = '1;
        h[0] = SIG_0;
        h[1] = SIG_1;
        h[2] = SIG_2;
        h[3] = SIG_3;
        send_header(h, HDR_BYTES);
      end

      // long output hold-off while bytes keep coming, so the block fills
      if (ph == 4) begin
        hold_asks <= hold_asks + 1;
      end

      for (int k = 0; k < HEADERS_PER_PHASE; k++) begin
        // sender pauses mid-phase until every record is back
        if (ph == 5 && k == HEADERS_PER_PHASE / 2) begin
          wait_quiet();
        end
        h = random_header();
        send_header(h, ($urandom_range(99) < 8) ? int'($urandom_range(1, 15)) : HDR_BYTES);
      end
    end

    wait_quiet();
    $display("sent %0d header bytes under %0d image sizes, %0d records checked",
             bytes_sent, sizes_used, records_checked);
    $display("of these %0d with a bad signature, %0d archaic, %0d with matching sizes",
             bad_sig_count, archaic_count, consistent_count);
    if (error_count == 0) begin
      $display("rom_header_decoder_core test passed");
    end else begin
      $display("rom_header_decoder_core test failed");
    end
    $finish;
  end

endmodule
